### hdl/line_fir_zero_border_assert.svh
`ifndef LINE_FIR_ZERO_BORDER_ASSERT_SVH
`define LINE_FIR_ZERO_BORDER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define LFZB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line_fir_zero_border check failed");

// next-cycle implication, clocked on clk, off during reset
`define LFZB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line_fir_zero_border check failed");

`endif

### hdl/lfzb_pkg.sv
package lfzb_pkg;

	localparam int MAX_TAPS     = 15;
	localparam int MAX_LINE_DEF = 4096;
	localparam int WIN_DEPTH    = 14;
	localparam int NUM_TAPS     = WIN_DEPTH + 1;
	localparam int COEF_WORDS   = 4;
	localparam int TAPS_PER_WORD = 4;
	localparam int RADIUS_W     = 3;
	localparam int RADIUS_LIM   = ((MAX_TAPS - 1) / 2 < WIN_DEPTH / 2) ?
		(MAX_TAPS - 1) / 2 : WIN_DEPTH / 2;
	localparam int SAMPLE_W     = 16;
	localparam int PROD_W       = 2 * SAMPLE_W;
	localparam int NUM_GROUPS   = (NUM_TAPS + TAPS_PER_WORD - 1) / TAPS_PER_WORD;
	localparam int PSUM_W       = PROD_W + 2;
	localparam int ACC_W        = PROD_W + 4;
	localparam int FRAC_W       = 15;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS = 3'd0,
		REG_COEF0  = 3'd1,
		REG_COEF1  = 3'd2,
		REG_COEF2  = 3'd3,
		REG_COEF3  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       line_end;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       last_of_line;
	} result_t;

	// what one input item turns into at the output
	typedef struct packed {
		logic                has_main;
		logic                conv;
		logic [RADIUS_W-1:0] zcnt;
		logic                last;
	} ctl_t;

endpackage

### hdl/line_fir_zero_border.sv
// first result: offered from stage s4, after the item passes stages s1, s2 and s3
// throughput: one item per cycle unless the output stalls; an item that ends a line
//   and owes r trailing zeros holds the output stage for them, stalling the input
// reset: asynchronous, active low; clears valid bits, line position, radius and taps;
//   the sample window is not cleared
`include "line_fir_zero_border_assert.svh"

module line_fir_zero_border #(
	parameter int MAX_LINE = lfzb_pkg::MAX_LINE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  lfzb_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output lfzb_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lfzb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lfzb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PW = $clog2(MAX_LINE + 1);
	localparam int SW = lfzb_pkg::SAMPLE_W;
	localparam int RW = lfzb_pkg::RADIUS_W;

	// configuration
	logic [RW-1:0]                    radius_q;
	logic [lfzb_pkg::CFG_DATA_W-1:0]  coef_q [lfzb_pkg::COEF_WORDS];
	logic signed [SW-1:0]             tap_c [lfzb_pkg::NUM_TAPS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			for (int w = 0; w < lfzb_pkg::COEF_WORDS; w++) coef_q[w] <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lfzb_pkg::REG_RADIUS: radius_q  <= cfg_data[RW-1:0];
				lfzb_pkg::REG_COEF0:  coef_q[0] <= cfg_data;
				lfzb_pkg::REG_COEF1:  coef_q[1] <= cfg_data;
				lfzb_pkg::REG_COEF2:  coef_q[2] <= cfg_data;
				lfzb_pkg::REG_COEF3:  coef_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int d = 0; d < lfzb_pkg::NUM_TAPS; d++)
			tap_c[d] = coef_q[d / lfzb_pkg::TAPS_PER_WORD]
				[SW * (d % lfzb_pkg::TAPS_PER_WORD) +: SW];
	end

	// stage enables, back to front
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;
	logic final_c, done_c;
	logic accept;

	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign item_ready = en1;
	assign accept = item_valid && en1;

	// input stage: line position, window and item control
	logic [PW-1:0]          position_q;
	logic signed [SW-1:0]   win_q [lfzb_pkg::NUM_TAPS];
	logic [RW-1:0]          r_eff_c;
	logic                   ge_r_c, ge_2r_c;
	lfzb_pkg::ctl_t         ctl_c, ctl_s1, ctl_s2, ctl_s3;
	logic [RW-1:0]          r_s1;

	always_comb begin
		r_eff_c = (radius_q > RW'(lfzb_pkg::RADIUS_LIM)) ? RW'(lfzb_pkg::RADIUS_LIM) : radius_q;
		ge_r_c  = position_q >= PW'(r_eff_c);
		ge_2r_c = position_q >= PW'({r_eff_c, 1'b0});
		ctl_c.has_main = ge_r_c;
		ctl_c.conv     = ge_2r_c;
		ctl_c.last     = item.line_end;
		if (!item.line_end)
			ctl_c.zcnt = '0;
		else if (ge_r_c)
			ctl_c.zcnt = r_eff_c;
		else
			ctl_c.zcnt = position_q[RW-1:0] + RW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (accept) begin
			if (item.line_end)
				position_q <= '0;
			else if (position_q < PW'(MAX_LINE))
				position_q <= position_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q[0] <= item.sample;
			for (int k = 1; k < lfzb_pkg::NUM_TAPS; k++) win_q[k] <= win_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s1   <= '0;
			r_s1     <= '0;
		end else if (en1) begin
			valid_s1 <= item_valid;
			ctl_s1   <= ctl_c;
			r_s1     <= r_eff_c;
		end
	end

	// products
	logic signed [lfzb_pkg::PROD_W-1:0] prod_s2 [lfzb_pkg::NUM_TAPS];

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int d = 0; d < lfzb_pkg::NUM_TAPS; d++) begin
				if (4'(d) <= {r_s1, 1'b0})
					prod_s2[d] <= win_q[d] * tap_c[d];
				else
					prod_s2[d] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ctl_s2   <= '0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
			ctl_s2   <= ctl_s1;
		end
	end

	// partial sums of up to four products
	logic signed [lfzb_pkg::PSUM_W-1:0] psum_c  [lfzb_pkg::NUM_GROUPS];
	logic signed [lfzb_pkg::PSUM_W-1:0] psum_s3 [lfzb_pkg::NUM_GROUPS];

	always_comb begin
		for (int g = 0; g < lfzb_pkg::NUM_GROUPS; g++) begin
			psum_c[g] = '0;
			for (int k = 0; k < lfzb_pkg::TAPS_PER_WORD; k++)
				if (lfzb_pkg::TAPS_PER_WORD * g + k < lfzb_pkg::NUM_TAPS)
					psum_c[g] = psum_c[g] +
						lfzb_pkg::PSUM_W'(prod_s2[lfzb_pkg::TAPS_PER_WORD * g + k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int g = 0; g < lfzb_pkg::NUM_GROUPS; g++) psum_s3[g] <= psum_c[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			ctl_s3   <= '0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
			ctl_s3   <= ctl_s2;
		end
	end

	// final sum, round half up, saturate
	logic signed [lfzb_pkg::ACC_W-1:0]            acc_c, rnd_c;
	logic signed [lfzb_pkg::ACC_W-lfzb_pkg::FRAC_W-1:0] shr_c;
	logic signed [SW-1:0]                         sat_c;

	always_comb begin
		acc_c = '0;
		for (int g = 0; g < lfzb_pkg::NUM_GROUPS; g++)
			acc_c = acc_c + lfzb_pkg::ACC_W'(psum_s3[g]);
		rnd_c = acc_c + (lfzb_pkg::ACC_W'(1) <<< (lfzb_pkg::FRAC_W - 1));
		shr_c = (lfzb_pkg::ACC_W - lfzb_pkg::FRAC_W)'(rnd_c >>> lfzb_pkg::FRAC_W);
		if (shr_c > (lfzb_pkg::ACC_W - lfzb_pkg::FRAC_W)'(signed'(32767)))
			sat_c = 16'sh7fff;
		else if (shr_c < (lfzb_pkg::ACC_W - lfzb_pkg::FRAC_W)'(signed'(-32768)))
			sat_c = 16'sh8000;
		else
			sat_c = shr_c[SW-1:0];
	end

	// result stage and line-end flush
	logic signed [SW-1:0] val_s4;
	logic                 has_main_s4;
	logic [RW-1:0]        zcnt_s4;
	logic                 last_s4;

	assign result_valid = valid_s4 && (has_main_s4 || zcnt_s4 != '0);
	assign final_c      = has_main_s4 ? (zcnt_s4 == '0) : (zcnt_s4 == RW'(1));
	assign done_c       = !result_valid || (result_ready && final_c);
	assign en4          = !valid_s4 || done_c;

	assign result.filtered     = has_main_s4 ? val_s4 : '0;
	assign result.last_of_line = last_s4 && final_c;

	always_ff @(posedge clk) begin
		if (en4) val_s4 <= ctl_s3.conv ? sat_c : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4    <= 1'b0;
			has_main_s4 <= 1'b0;
			zcnt_s4     <= '0;
			last_s4     <= 1'b0;
		end else if (en4) begin
			valid_s4    <= valid_s3;
			has_main_s4 <= ctl_s3.has_main;
			zcnt_s4     <= ctl_s3.zcnt;
			last_s4     <= ctl_s3.last;
		end else if (result_ready) begin
			if (has_main_s4)
				has_main_s4 <= 1'b0;
			else
				zcnt_s4 <= zcnt_s4 - RW'(1);
		end
	end

	// checks
	`LFZB_ASSERT_IMP(a_stall_needs_item, !item_ready, valid_s1)
	`LFZB_ASSERT_IMP(a_zeros_only_at_line_end, valid_s4 && zcnt_s4 != '0, last_s4)
	`LFZB_ASSERT_NEXT(a_line_end_resets_pos, item_valid && item_ready && item.line_end, position_q == '0)
	`LFZB_ASSERT_NEXT(a_flush_no_gap, result_valid && result_ready && !final_c, result_valid)

endmodule
